[rtl/iwfc_pkg.sv]
// shared types, codes and a byte-wise crc-8 helper for the frame check
`default_nettype none
package iwfc_pkg;

  localparam int NUM_CELLS = 6;
  localparam int ADDR_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic       DIR_WRITE = 1'b0;
  localparam logic       DIR_READ  = 1'b1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE     = 1'b1;

  localparam logic [1:0] LEN_PLAIN = 2'd2;
  localparam logic [1:0] LEN_CRC   = 2'd3;

  // byte position within the frame, one per cell
  typedef enum logic [2:0] {
    STEP_ADDR_W = 3'd0,
    STEP_REG    = 3'd1,
    STEP_THIRD  = 3'd2,
    STEP_FOURTH = 3'd3,
    STEP_FIFTH  = 3'd4,
    STEP_SIXTH  = 3'd5,
    STEP_DONE   = 3'd6
  } step_t;

  typedef struct packed {
    logic              op;
    logic              crc_en;
    logic [ADDR_W-1:0] dev_addr;
    logic [7:0]        reg_byte;
    logic [15:0]       data_word;
    logic [7:0]        rx_crc;
    logic [7:0]        crc;
    step_t             step;
  } item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/iwfc_cell.sv]
// one crc cell: folds the frame byte of its position into the running crc
`default_nettype none
module iwfc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire iwfc_pkg::item_t item_in,
  output logic                 valid_out,
  output iwfc_pkg::item_t      item_out
);
  import iwfc_pkg::*;

  logic       valid_r;
  item_t      item_r;
  item_t      item_nxt;
  logic [7:0] frame_byte;
  logic       use_byte;
  logic [7:0] addr_w;
  logic [7:0] addr_r;

  assign addr_w = {item_in.dev_addr, DIR_WRITE};
  assign addr_r = {item_in.dev_addr, DIR_READ};

  // write frames are four bytes long, the last two cells just pass through
  always_comb begin
    frame_byte = 8'h00;
    use_byte   = 1'b1;
    unique case (item_in.step)
      STEP_ADDR_W: frame_byte = addr_w;
      STEP_REG:    frame_byte = item_in.reg_byte;
      STEP_THIRD:  frame_byte = (item_in.op == OP_WRITE) ? item_in.data_word[15:8] : addr_r;
      STEP_FOURTH: frame_byte = (item_in.op == OP_WRITE) ? item_in.data_word[7:0]
                                                         : item_in.reg_byte;
      STEP_FIFTH: begin
        frame_byte = item_in.data_word[7:0];
        use_byte   = (item_in.op == OP_READ);
      end
      STEP_SIXTH: begin
        frame_byte = item_in.data_word[15:8];
        use_byte   = (item_in.op == OP_READ);
      end
      default: use_byte = 1'b0;
    endcase
  end

  always_comb begin
    item_nxt      = item_in;
    item_nxt.crc  = use_byte ? crc8_byte(item_in.crc, frame_byte) : item_in.crc;
    item_nxt.step = step_t'(item_in.step + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;

endmodule
`default_nettype wire

[rtl/i2c_word_frame_crc8_check.sv]
// top level of the i2c word frame crc-8 packet error check
`default_nettype none
// Packet error check for 16-bit register accesses to an I2C device (CRC-8,
// polynomial 0x07, initial value zero, msb first). A read transaction
// (op 0) runs the crc over write address, register, read address, register
// and the two received bytes and compares it with received_crc; a write
// transaction (op 1) runs it over write address, register, high and low
// byte and returns the bytes to send. One transaction is taken every clock
// cycle while the row advances; it then passes through a row of six
// identical cells, each of which folds the frame byte of its position, if
// any, into the running crc and hands it on. The whole row halts while a
// result waits on out_ready, so in_ready falls only then. Configuration is
// sampled with each transaction as it enters and should be written while idle.
module i2c_word_frame_crc8_check (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [iwfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iwfc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_op,
  input  wire logic [7:0]                     in_reg_byte,
  input  wire logic [15:0]                    in_data_word,
  input  wire logic [7:0]                     in_received_crc,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [15:0]                         out_read_value,
  output logic [7:0]                          out_tx_first_byte,
  output logic [7:0]                          out_tx_second_byte,
  output logic [7:0]                          out_crc_out,
  output logic [1:0]                          out_frame_length,
  output logic                                out_status
);
  import iwfc_pkg::*;

  logic [ADDR_W-1:0] dev_addr_r;
  logic              crc_en_r;

  logic              valid_chain [0:NUM_CELLS];
  item_t             item_chain  [0:NUM_CELLS];
  logic              advance;
  item_t             last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_W'(1);
      crc_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata[ADDR_W-1:0];
        CFG_CRC_ENABLE:     crc_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // whole row moves together unless the result at the end is held
  assign advance  = !valid_chain[NUM_CELLS] || out_ready;
  assign in_ready = advance;

  // entry of the row: the transaction with its configuration snapshot
  always_comb begin
    item_chain[0].op        = in_op;
    item_chain[0].crc_en    = crc_en_r;
    item_chain[0].dev_addr  = dev_addr_r;
    item_chain[0].reg_byte  = in_reg_byte;
    item_chain[0].data_word = in_data_word;
    item_chain[0].rx_crc    = in_received_crc;
    item_chain[0].crc       = 8'h00;
    item_chain[0].step      = STEP_ADDR_W;
  end
  assign valid_chain[0] = in_valid;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    iwfc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .valid_in  (valid_chain[k]),
      .item_in   (item_chain[k]),
      .valid_out (valid_chain[k+1]),
      .item_out  (item_chain[k+1])
    );
  end

  // result formatting from the last cell's register
  assign last      = item_chain[NUM_CELLS];
  assign out_valid = valid_chain[NUM_CELLS];

  always_comb begin
    out_read_value     = (last.op == OP_READ)  ? last.data_word : 16'h0000;
    out_tx_first_byte  = (last.op == OP_WRITE) ? last.data_word[15:8] : 8'h00;
    out_tx_second_byte = (last.op == OP_WRITE) ? last.data_word[7:0] : 8'h00;
    out_crc_out        = last.crc_en ? last.crc : 8'h00;
    out_frame_length   = last.crc_en ? LEN_CRC : LEN_PLAIN;
    out_status         = last.crc_en && (last.op == OP_READ) && (last.crc != last.rx_crc);
  end

  // a finished transaction has been through every cell
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last.step == STEP_DONE))
    else $error("result left the row before every frame byte was folded in");

  // a mismatch is only reported on a crc frame
  a_status_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_frame_length == LEN_CRC))
    else $error("crc mismatch flagged on a plain frame");

  // read and write payloads never mix
  a_payload_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != 16'h0000)) |->
      (out_tx_first_byte == 8'h00 && out_tx_second_byte == 8'h00))
    else $error("read value and write bytes both present");

  // reset empties the row
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire

[test/i2c_word_frame_crc8_check_tb.sv]
// self-checking bench for the i2c word frame crc-8 packet error check
`timescale 1ns / 1ps
module i2c_word_frame_crc8_check_tb;
  import iwfc_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  // random transactions per configuration phase
  localparam int PHASE_ITEMS = 135;
  localparam int NUM_PHASES = 8;

  // one result transaction, as the block presents it
  typedef struct packed {
    logic [15:0] read_value;
    logic [7:0]  tx_first;
    logic [7:0]  tx_second;
    logic [7:0]  crc;
    logic [1:0]  frame_len;
    logic        status;
  } frame_result_t;

  // holds a copy of the two registers, predicts each frame and checks results in order
  class pec_scoreboard;
    logic [ADDR_W-1:0] dev_addr;
    logic              crc_en;
    frame_result_t     awaited[$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      dev_addr     = 7'd1;
      crc_en       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_DEVICE_ADDRESS) begin
        dev_addr = val[ADDR_W-1:0];
      end else if (idx == CFG_CRC_ENABLE) begin
        crc_en = val[0];
      end
    endfunction

    // bit-serial crc-8 step, msb of the byte first
    function logic [7:0] fold(logic [7:0] acc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = acc[7] ^ b[i];
        acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
    endfunction

    // crc of the whole frame under the current register copy
    function logic [7:0] frame_pec(logic op, logic [7:0] reg_byte, logic [15:0] word);
      logic [7:0] acc;
      acc = fold(8'h00, {dev_addr, DIR_WRITE});
      acc = fold(acc, reg_byte);
      if (op == OP_READ) begin
        acc = fold(acc, {dev_addr, DIR_READ});
        acc = fold(acc, reg_byte);
        acc = fold(acc, word[7:0]);
        acc = fold(acc, word[15:8]);
      end else begin
        acc = fold(acc, word[15:8]);
        acc = fold(acc, word[7:0]);
      end
      return acc;
    endfunction

    function void note_request(logic op, logic [7:0] reg_byte, logic [15:0] word,
                               logic [7:0] rx_crc);
      frame_result_t r;
      r           = '0;
      r.frame_len = LEN_PLAIN;
      if (op == OP_READ) begin
        r.read_value = word;
      end else begin
        r.tx_first  = word[15:8];
        r.tx_second = word[7:0];
      end
      if (crc_en) begin
        r.crc       = frame_pec(op, reg_byte, word);
        r.frame_len = LEN_CRC;
        if (op == OP_READ) begin
          r.status = (r.crc != rx_crc);
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      string         bad;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing outstanding: rv=%04h tx=%02h/%02h crc=%02h",
                   results_seen, got.read_value, got.tx_first, got.tx_second, got.crc);
        end
        return;
      end
      want = awaited.pop_front();
      bad  = "";
      if (got.read_value !== want.read_value) bad = {bad, " read_value"};
      if (got.tx_first !== want.tx_first) bad = {bad, " tx_first_byte"};
      if (got.tx_second !== want.tx_second) bad = {bad, " tx_second_byte"};
      if (got.crc !== want.crc) bad = {bad, " crc_out"};
      if (got.frame_len !== want.frame_len) bad = {bad, " frame_length"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d wrong:%s | exp rv=%04h tx=%02h/%02h crc=%02h len=%0d st=%0b",
                   results_seen, bad, want.read_value, want.tx_first, want.tx_second,
                   want.crc, want.frame_len, want.status);
          $display("    got rv=%04h tx=%02h/%02h crc=%02h len=%0d st=%0b",
                   got.read_value, got.tx_first, got.tx_second, got.crc,
                   got.frame_len, got.status);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEVICE_ADDRESS;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_op           = OP_READ;
  logic [7:0]  in_reg_byte     = 8'h00;
  logic [15:0] in_data_word    = 16'h0000;
  logic [7:0]  in_received_crc = 8'h00;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_read_value;
  logic [7:0]  out_tx_first_byte;
  logic [7:0]  out_tx_second_byte;
  logic [7:0]  out_crc_out;
  logic [1:0]  out_frame_length;
  logic        out_status;

  // random idling on either side, switched off for one whole phase
  logic idle_in  = 1'b1;
  logic idle_out = 1'b1;

  int unsigned   quiet_cycles = 0;
  pec_scoreboard sb = new();

  i2c_word_frame_crc8_check dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_reg_byte       (in_reg_byte),
    .in_data_word      (in_data_word),
    .in_received_crc   (in_received_crc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_tx_first_byte (out_tx_first_byte),
    .out_tx_second_byte(out_tx_second_byte),
    .out_crc_out       (out_crc_out),
    .out_frame_length  (out_frame_length),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure, stalled about 17 percent of the time
  always @(posedge clk) begin
    out_ready <= !idle_out || ($urandom_range(99) >= 17);
  end

  // monitor: values read here are those sampled at this edge, since every
  // bench input changes by nonblocking assignment after it
  always @(posedge clk) begin
    frame_result_t got;
    logic          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_op, in_reg_byte, in_data_word, in_received_crc);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        got.read_value = out_read_value;
        got.tx_first   = out_tx_first_byte;
        got.tx_second  = out_tx_second_byte;
        got.crc        = out_crc_out;
        got.frame_len  = out_frame_length;
        got.status     = out_status;
        sb.check_result(got);
        moved = 1'b1;
      end
    end
    // watchdog on cycles with no transaction on either channel
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("i2c_word_frame_crc8_check: mismatch");
      $finish;
    end
  end

  // present one frame and hold it until the block takes it
  task automatic send_frame(input logic op, input logic [7:0] reg_byte,
                            input logic [15:0] word, input logic [7:0] rx_crc);
    while (idle_in && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_reg_byte     <= reg_byte;
    in_data_word    <= word;
    in_received_crc <= rx_crc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // read frame whose crc byte is the right one, optionally with bits flipped
  task automatic send_read_pec(input logic [7:0] reg_byte, input logic [15:0] word,
                               input logic [7:0] flip);
    logic [7:0] pec;
    pec = sb.frame_pec(OP_READ, reg_byte, word) ^ flip;
    send_frame(OP_READ, reg_byte, word, pec);
  endtask

  // let the pipe drain, then write both registers while nothing is in flight
  task automatic settle_and_configure(input logic [ADDR_W-1:0] dev, input logic en);
    logic [CFG_DAT_W-1:0] en_word;
    in_valid <= 1'b0;
    // one edge so the monitor has noted the last accepted frame
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // six-stage row, allow a little more than its depth
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= dev;
    @(posedge clk);
    sb.set_config(CFG_DEVICE_ADDRESS, dev);
    // upper bits of the enable write carry noise, only bit 0 counts
    en_word    = CFG_DAT_W'($urandom);
    en_word[0] = en;
    cfg_index <= CFG_CRC_ENABLE;
    cfg_wdata <= en_word;
    @(posedge clk);
    sb.set_config(CFG_CRC_ENABLE, en_word);
    cfg_we <= 1'b0;
  endtask

  // random frame: about half the reads carry the right crc, a quarter a
  // single flipped bit and the rest noise
  task automatic random_frame();
    logic        op;
    logic [7:0]  reg_byte;
    logic [15:0] word;
    logic [7:0]  rx_crc;
    int          pick;
    op   = 1'($urandom_range(1, 0));
    pick = $urandom_range(9);
    reg_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
    pick = $urandom_range(9);
    word = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff : 16'($urandom);
    rx_crc = sb.frame_pec(OP_READ, reg_byte, word);
    pick   = $urandom_range(3);
    if (pick == 2) begin
      rx_crc = rx_crc ^ (8'h01 << $urandom_range(7));
    end else if (pick == 3) begin
      rx_crc = 8'($urandom);
    end
    send_frame(op, reg_byte, word, rx_crc);
  endtask

  initial begin
    logic [ADDR_W-1:0] ph_dev;
    logic              ph_en;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: address 1, crc off, so reads pass whatever the crc byte
    send_frame(OP_READ, 8'h00, 16'h0000, 8'h00);
    send_frame(OP_WRITE, 8'hff, 16'hffff, 8'hff);
    send_frame(OP_READ, 8'hff, 16'hffff, 8'h5a);
    send_frame(OP_WRITE, 8'h00, 16'h1234, 8'h00);

    // top address with crc on: good and bad crc bytes, field extremes
    settle_and_configure(7'h7f, 1'b1);
    send_read_pec(8'h00, 16'h0000, 8'h00);
    send_read_pec(8'hff, 16'hffff, 8'h00);
    send_read_pec(8'hff, 16'hffff, 8'h01);
    send_read_pec(8'h5a, 16'h00ff, 8'h80);
    send_frame(OP_READ, 8'ha5, 16'hff00, 8'h00);
    send_frame(OP_READ, 8'h3c, 16'h8001, 8'hff);
    send_frame(OP_WRITE, 8'h00, 16'h0000, 8'h00);
    send_frame(OP_WRITE, 8'hff, 16'hffff, 8'hff);
    send_frame(OP_WRITE, 8'h12, 16'h8001, 8'h5a);

    // address zero is taken as given
    settle_and_configure(7'h00, 1'b1);
    send_read_pec(8'h81, 16'h7e18, 8'h00);
    send_read_pec(8'h81, 16'h7e18, 8'hff);
    send_frame(OP_WRITE, 8'h81, 16'h7e18, 8'h00);

    // random phases across register settings, one without any idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      ph_dev   = ADDR_W'($urandom);
      ph_en    = 1'b1;
      idle_in  = 1'b1;
      idle_out = 1'b1;
      case (p)
        1: ph_dev = 7'h00;
        2: begin
          ph_dev = 7'h7f;
          ph_en  = 1'b0;
        end
        3: begin
          idle_in  = 1'b0;
          idle_out = 1'b0;
        end
        4: ph_en = 1'b0;
        5: ph_dev = 7'h7f;
        default: ;
      endcase
      settle_and_configure(ph_dev, ph_en);
      repeat (PHASE_ITEMS) random_frame();
    end

    // wait for every outstanding result, then idle on to catch strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("i2c_word_frame_crc8_check: match");
    end else begin
      $display("i2c_word_frame_crc8_check: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/iwfc_pkg.sv
rtl/iwfc_cell.sv
rtl/i2c_word_frame_crc8_check.sv
test/i2c_word_frame_crc8_check_tb.sv
